// ===== sv/rmq_pkg.sv =====
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IN_W          = 16;
    localparam int NUM_IN        = 9;
    localparam int NUM_LANES     = 4;
    localparam int W_OUT_W       = 15;
    localparam int XYZ_OUT_W     = 16;
    localparam int MAG_MAX       = 32767;

    localparam int LANE_W = 0;
    localparam int LANE_X = 1;
    localparam int LANE_Y = 2;
    localparam int LANE_Z = 3;

    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic neg_z;
    } rmq_sign_t;

    // Width of a signed diagonal sum, wide enough for one plus three full-range entries.
    function automatic int rmq_sum_w(input int fb);
        return ((fb > 17) ? fb : 17) + 2;
    endfunction

    // Width of the radicand (clamped sum times one), rounded up to an even count.
    function automatic int rmq_rad_w(input int fb);
        int p;
        p = rmq_sum_w(fb) - 1 + fb;
        return p + (p & 1);
    endfunction

endpackage

// ===== sv/rotation_matrix_to_quaternion.sv =====
// Converts a 3x3 rotation matrix into a unit quaternion with FRAC_BITS fraction
// bits; the matrix and quaternion x, y, z are signed fixed point, w unsigned.
// The matrix arrives on the slave stream (s_tvalid, s_tready, s_tdata) and the
// quaternion leaves on the master stream (m_tvalid, m_tready, m_tdata); every
// input transfer yields exactly one output transfer, in order.
// The block takes one matrix per clock cycle when the output is not stalled.
// An entry stage forms the four clamped diagonal sums, a square-root pipeline
// finds one root bit for all four parts per stage, ROOT_W bits in all, where
// ROOT_W is half the radicand width, and an output stage halves, saturates
// and applies the signs.
// Each stage holds its item until the next stage can take it, so a stall on
// m_tready fills the empty stages first and only then lowers s_tready;
// nothing is lost or repeated.
// Reset clears every valid bit; the pipeline is empty and ready afterwards.
module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // r00, r01, r02, r10, r11, r12, r20, r21, r22; 16 bits each from bit 0 up.
    input  logic [143:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // quat_w [14:0], quat_x [30:15], quat_y [46:31], quat_z [62:47], bit 63 zero.
    output logic [63:0]  m_tdata
);

    localparam int SUM_W  = rmq_sum_w(FRAC_BITS);
    localparam int MAG_W  = SUM_W - 1;
    localparam int RAD_W  = rmq_rad_w(FRAC_BITS);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int HALF_W = ROOT_W - 1;

    logic signed [IN_W-1:0]  r [NUM_IN];
    logic signed [SUM_W-1:0] ext [NUM_IN];
    logic signed [SUM_W-1:0] one_fx;
    logic signed [SUM_W-1:0] sum [NUM_LANES];
    logic [MAG_W-1:0]        mag [NUM_LANES];
    logic [IN_W:0]           diff_x;
    logic [IN_W:0]           diff_y;
    logic [IN_W:0]           diff_z;

    logic [NUM_LANES-1:0][RAD_W-1:0] rad_next;
    rmq_sign_t                       sign_next;

    logic                            s0_valid_reg;
    logic [NUM_LANES-1:0][RAD_W-1:0] s0_rad_reg;
    rmq_sign_t                       s0_sign_reg;
    logic                            s0_ready;

    logic [NUM_LANES-1:0][RAD_W-1:0]  rad_c   [0:ROOT_W];
    logic [NUM_LANES-1:0][REM_W-1:0]  rem_c   [0:ROOT_W];
    logic [NUM_LANES-1:0][ROOT_W-1:0] root_c  [0:ROOT_W];
    rmq_sign_t                        sign_c  [0:ROOT_W];
    logic                             valid_c [0:ROOT_W];
    logic                             ready_c [0:ROOT_W];

    logic [HALF_W-1:0]          half [NUM_LANES];
    logic [W_OUT_W-1:0]         mag_sat [NUM_LANES];
    logic [W_OUT_W-1:0]         quat_w_next;
    logic [XYZ_OUT_W-1:0]       quat_x_next;
    logic [XYZ_OUT_W-1:0]       quat_y_next;
    logic [XYZ_OUT_W-1:0]       quat_z_next;

    logic                       out_valid_reg;
    logic [W_OUT_W-1:0]         quat_w_reg;
    logic [XYZ_OUT_W-1:0]       quat_x_reg;
    logic [XYZ_OUT_W-1:0]       quat_y_reg;
    logic [XYZ_OUT_W-1:0]       quat_z_reg;
    logic                       out_ready;

    // Entry stage: diagonal sums, clamping and sign differences.
    always_comb
    begin
        for (int k = 0; k < NUM_IN; k++)
        begin
            r[k]   = s_tdata[k*IN_W +: IN_W];
            ext[k] = SUM_W'(r[k]);
        end
        one_fx = SUM_W'(1) << FRAC_BITS;
        sum[LANE_W] = one_fx + ext[0] + ext[4] + ext[8];
        sum[LANE_X] = one_fx + ext[0] - ext[4] - ext[8];
        sum[LANE_Y] = one_fx - ext[0] + ext[4] - ext[8];
        sum[LANE_Z] = one_fx - ext[0] - ext[4] + ext[8];
        for (int i = 0; i < NUM_LANES; i++)
        begin
            mag[i]      = (sum[i] <= 0) ? '0 : sum[i][MAG_W-1:0];
            rad_next[i] = RAD_W'({mag[i], {FRAC_BITS{1'b0}}});
        end
        diff_x = {r[7][IN_W-1], r[7]} - {r[5][IN_W-1], r[5]};
        diff_y = {r[2][IN_W-1], r[2]} - {r[6][IN_W-1], r[6]};
        diff_z = {r[3][IN_W-1], r[3]} - {r[1][IN_W-1], r[1]};
        sign_next.neg_x = diff_x[IN_W];
        sign_next.neg_y = diff_y[IN_W];
        sign_next.neg_z = diff_z[IN_W];
    end

    assign s0_ready = !s0_valid_reg || ready_c[0];
    assign s_tready = s0_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (s0_ready)
        begin
            s0_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s0_ready)
        begin
            s0_rad_reg  <= rad_next;
            s0_sign_reg <= sign_next;
        end
    end

    assign valid_c[0] = s0_valid_reg;
    assign rad_c[0]   = s0_rad_reg;
    assign rem_c[0]   = '0;
    assign root_c[0]  = '0;
    assign sign_c[0]  = s0_sign_reg;

    // Square-root pipeline: one stage per root bit.
    for (genvar g = 0; g < ROOT_W; g++)
    begin : g_root
        rmq_root_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid_c[g]),
            .in_ready  (ready_c[g]),
            .in_rad    (rad_c[g]),
            .in_rem    (rem_c[g]),
            .in_root   (root_c[g]),
            .in_sign   (sign_c[g]),
            .out_valid (valid_c[g+1]),
            .out_ready (ready_c[g+1]),
            .out_rad   (rad_c[g+1]),
            .out_rem   (rem_c[g+1]),
            .out_root  (root_c[g+1]),
            .out_sign  (sign_c[g+1])
        );
    end

    // Output stage: halve the root, saturate and apply the signs.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            half[i]    = root_c[ROOT_W][i][ROOT_W-1:1];
            mag_sat[i] = (32'(half[i]) > 32'(MAG_MAX)) ? W_OUT_W'(MAG_MAX) : W_OUT_W'(half[i]);
        end
        quat_w_next = mag_sat[LANE_W];
        quat_x_next = sign_c[ROOT_W].neg_x ? (XYZ_OUT_W'(0) - {1'b0, mag_sat[LANE_X]})
                                           : {1'b0, mag_sat[LANE_X]};
        quat_y_next = sign_c[ROOT_W].neg_y ? (XYZ_OUT_W'(0) - {1'b0, mag_sat[LANE_Y]})
                                           : {1'b0, mag_sat[LANE_Y]};
        quat_z_next = sign_c[ROOT_W].neg_z ? (XYZ_OUT_W'(0) - {1'b0, mag_sat[LANE_Z]})
                                           : {1'b0, mag_sat[LANE_Z]};
    end

    assign out_ready       = !out_valid_reg || m_tready;
    assign ready_c[ROOT_W] = out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= valid_c[ROOT_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_c[ROOT_W] && out_ready)
        begin
            quat_w_reg <= quat_w_next;
            quat_x_reg <= quat_x_next;
            quat_y_reg <= quat_y_next;
            quat_z_reg <= quat_z_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, quat_z_reg, quat_y_reg, quat_x_reg, quat_w_reg};

endmodule

// ===== sv/rmq_root_step.sv =====
module rmq_root_step
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                                      clk,
    input  logic                                                      rst_n,
    input  logic                                                      in_valid,
    output logic                                                      in_ready,
    input  logic [NUM_LANES-1:0][rmq_rad_w(FRAC_BITS)-1:0]            in_rad,
    input  logic [NUM_LANES-1:0][rmq_rad_w(FRAC_BITS)/2+2:0]          in_rem,
    input  logic [NUM_LANES-1:0][rmq_rad_w(FRAC_BITS)/2-1:0]          in_root,
    input  rmq_sign_t                                                 in_sign,
    output logic                                                      out_valid,
    input  logic                                                      out_ready,
    output logic [NUM_LANES-1:0][rmq_rad_w(FRAC_BITS)-1:0]            out_rad,
    output logic [NUM_LANES-1:0][rmq_rad_w(FRAC_BITS)/2+2:0]          out_rem,
    output logic [NUM_LANES-1:0][rmq_rad_w(FRAC_BITS)/2-1:0]          out_root,
    output rmq_sign_t                                                 out_sign
);

    localparam int RAD_W  = rmq_rad_w(FRAC_BITS);
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;

    logic                                 valid_reg;
    logic [NUM_LANES-1:0][RAD_W-1:0]      rad_reg;
    logic [NUM_LANES-1:0][REM_W-1:0]      rem_reg;
    logic [NUM_LANES-1:0][ROOT_W-1:0]     root_reg;
    rmq_sign_t                            sign_reg;

    logic [NUM_LANES-1:0][RAD_W-1:0]      rad_next;
    logic [NUM_LANES-1:0][REM_W-1:0]      rem_next;
    logic [NUM_LANES-1:0][ROOT_W-1:0]     root_next;
    logic [NUM_LANES-1:0][REM_W-1:0]      rem_sh;
    logic [NUM_LANES-1:0][REM_W-1:0]      trial;

    assign in_ready = !valid_reg || out_ready;

    // One result bit per lane: bring down the next two radicand bits and try root*4+1.
    always_comb
    begin
        for (int i = 0; i < NUM_LANES; i++)
        begin
            rem_sh[i]   = {in_rem[i][REM_W-3:0], in_rad[i][RAD_W-1 -: 2]};
            trial[i]    = {1'b0, in_root[i], 2'b01};
            rad_next[i] = in_rad[i] << 2;
            if (rem_sh[i] >= trial[i])
            begin
                rem_next[i]  = rem_sh[i] - trial[i];
                root_next[i] = {in_root[i][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i]  = rem_sh[i];
                root_next[i] = {in_root[i][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            sign_reg <= in_sign;
        end
    end

    assign out_valid = valid_reg;
    assign out_rad   = rad_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_sign  = sign_reg;

endmodule
